>>> rtl/arpcr_pkg.sv
// Shared types and constants of the ARP resolver cache.
// Depends on nothing; arpcr_result_buf, the core and the testbench import it.
`timescale 1ns / 1ps

package arpcr_pkg;

  localparam int HANDLE_W = 8;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int TIME_W   = 32;
  localparam int RETRY_W  = 4;

  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] ACT_TX    = 2'd0;
  localparam logic [1:0] ACT_REQ   = 2'd1;
  localparam logic [1:0] ACT_REPLY = 2'd2;
  localparam logic [1:0] ACT_DROP  = 2'd3;

  localparam logic [1:0] REG_OWN_IP    = 2'd0;
  localparam logic [1:0] REG_RETRY     = 2'd1;
  localparam logic [1:0] REG_EXPIRE    = 2'd2;
  localparam logic [1:0] REG_MAX_RETRY = 2'd3;

  localparam logic [15:0]        RETRY_RESET     = 16'd1000;
  localparam logic [TIME_W-1:0]  EXPIRE_RESET    = 32'd60000;
  localparam logic [RETRY_W-1:0] MAX_RETRY_RESET = 4'd3;

  localparam logic [10:0] MIN_FRAME_LEN = 11'd28;
  localparam logic [15:0] HW_ETHER      = 16'h0001;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [15:0] ADDR_LENS     = 16'h0604;
  localparam logic [15:0] ARP_REQUEST   = 16'd1;
  localparam logic [15:0] ARP_REPLY     = 16'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [HANDLE_W-1:0] handle;
    logic [MAC_W-1:0]    mac;
    logic [IP_W-1:0]     ip;
  } result_t;

  typedef struct packed {
    logic emit;
    logic finish;
  } rbuf_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LK_WAIT,
    ST_LK_CHK,
    ST_SEND_TX,
    ST_SEND_Q,
    ST_EV_WAIT,
    ST_EV_CHK,
    ST_ALLOC_SET,
    ST_ALLOC_REQ,
    ST_REPLY_FILL,
    ST_REQ_ANSWER,
    ST_DRAIN,
    ST_TICK_NEXT,
    ST_TK_WAIT,
    ST_TK_CHK,
    ST_TK_RETRY,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/arpcr_entry_mem.sv
// Entry record memory: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module arpcr_entry_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/arpcr_result_buf.sv
// Result staging: one held beat plus the output register; marks the final beat.
// Depends on arpcr_pkg.
`timescale 1ns / 1ps

module arpcr_result_buf
  import arpcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rbuf_ctl_t ctl,
  input  result_t   emit_data,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_data,
  output logic      out_last
);

  result_t hold;
  logic    hold_valid;
  logic    out_free;
  logic    push;

  assign out_free = !out_valid || out_ready;
  assign room     = !hold_valid || out_free;
  assign push     = hold_valid && (ctl.emit || ctl.finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.emit) begin
        hold_valid <= 1'b1;
      end else if (ctl.finish) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= hold;
      out_last <= ctl.finish;
    end
    if (ctl.emit) begin
      hold <= emit_data;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst) ctl.emit |-> room)
    else $error("result pushed without room");
  a_finish_room: assert property (@(posedge clk) disable iff (rst) ctl.finish |-> room)
    else $error("item closed without room");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst) !(ctl.emit && ctl.finish))
    else $error("emit and finish together");

endmodule

>>> rtl/arp_cache_resolver_core.sv
// Top level of the ARP resolver cache: sequencer, flags, allocation order, config.
// Depends on arpcr_pkg, arpcr_entry_mem, arpcr_result_buf.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Beat
// in       sink       in_valid / in_ready    opcode, time, handle, next hop, ARP fields
// out      source     out_valid / out_ready  action, out_handle, out_mac, out_ip, last
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Send and reply lookups scan the entry memory one entry at a time; a send that
// allocates a new entry also emits its request beat. Eviction frees the oldest entry
// and drops each of its queued handles. A tick visits the live entries in allocation
// order, re-sending requests and freeing entries along with their queued handles.
// A request answer emits a single reply beat.
// Flags sit in flip-flops, so there is no clearing pass after reset. Output stalls hold
// the sequencer.

module arp_cache_resolver_core
  import arpcr_pkg::*;
#(
  parameter int ENTRY_COUNT = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [HANDLE_W-1:0] packet_handle,
  input  logic [IP_W-1:0]     dest_ip,
  input  logic [10:0]         frame_length,
  input  logic [15:0]         hw_type,
  input  logic [15:0]         proto_type,
  input  logic [15:0]         addr_lengths,
  input  logic [15:0]         arp_op,
  input  logic [MAC_W-1:0]    sender_mac,
  input  logic [IP_W-1:0]     sender_ip,
  input  logic [IP_W-1:0]     tgt_ip,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          action,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [MAC_W-1:0]    out_mac,
  output logic [IP_W-1:0]     out_ip,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int IW  = $clog2(ENTRY_COUNT);
  localparam int UCW = $clog2(ENTRY_COUNT + 1);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef logic [QUEUE_DEPTH-1:0][HANDLE_W-1:0] hq_t;

  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [TIME_W-1:0]  stamp;
    logic [RETRY_W-1:0] retries;
    logic [CW-1:0]      count;
    hq_t                handles;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  logic [IP_W-1:0]    own_ip;
  logic [15:0]        retry_ms;
  logic [TIME_W-1:0]  expire_ms;
  logic [RETRY_W-1:0] max_retries;

  state_t state, state_next;
  state_t ret_state, ret_state_next;
  logic [IW-1:0]  cur_idx, cur_idx_next;
  logic [UCW-1:0] pos, pos_next;
  logic [UCW-1:0] used_count, used_count_next;
  logic [CW-1:0]  qi, qi_next;
  logic           reply_mode, reply_mode_next;
  logic [1:0]     drain_act, drain_act_next;
  logic [MAC_W-1:0] drain_mac, drain_mac_next;
  rec_t           rec, rec_next;
  logic [ENTRY_COUNT-1:0] in_use, in_use_next;
  logic [ENTRY_COUNT-1:0] resolved, resolved_next;
  logic [IW-1:0]  order [ENTRY_COUNT];
  logic [IW-1:0]  order_next [ENTRY_COUNT];

  logic [IP_W-1:0]     key;
  logic [TIME_W-1:0]   now_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [MAC_W-1:0]    smac_q;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  rec_t             mem_wdata;
  logic [REC_W-1:0] mem_rbits;
  rec_t             mem_rdata;

  rbuf_ctl_t ctl;
  result_t   emit_data;
  result_t   out_res;
  logic      room;

  logic          accept;
  logic          hdr_ok;
  logic          reply_ok;
  logic          request_ok;
  logic [IW-1:0] free_e;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign mem_rdata = rec_t'(mem_rbits);

  assign hdr_ok = (frame_length >= MIN_FRAME_LEN) && (hw_type == HW_ETHER) &&
                  (proto_type == PROTO_IPV4) && (addr_lengths == ADDR_LENS);
  assign reply_ok = hdr_ok && (arp_op == ARP_REPLY) && (sender_ip != tgt_ip) &&
                    (tgt_ip == own_ip);
  assign request_ok = hdr_ok && (arp_op == ARP_REQUEST) && (sender_ip != '0) &&
                      (sender_ip != tgt_ip) && (tgt_ip == own_ip);

  always_comb begin
    free_e = '0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_e = IW'(i);
      end
    end
  end

  arpcr_entry_mem #(
    .DEPTH(ENTRY_COUNT),
    .WIDTH(REC_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(cur_idx),
    .rdata(mem_rbits)
  );

  arpcr_result_buf u_rbuf (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .emit_data(emit_data),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_res),
    .out_last (last)
  );

  assign action     = out_res.action;
  assign out_handle = out_res.handle;
  assign out_mac    = out_res.mac;
  assign out_ip     = out_res.ip;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip      <= '0;
      retry_ms    <= RETRY_RESET;
      expire_ms   <= EXPIRE_RESET;
      max_retries <= MAX_RETRY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN_IP:    own_ip      <= cfg_data;
        REG_RETRY:     retry_ms    <= cfg_data[15:0];
        REG_EXPIRE:    expire_ms   <= cfg_data;
        REG_MAX_RETRY: max_retries <= cfg_data[RETRY_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= (opcode == OP_SEND) ? dest_ip : sender_ip;
      now_q    <= now_ms;
      handle_q <= packet_handle;
      smac_q   <= sender_mac;
    end
    rec       <= rec_next;
    drain_mac <= drain_mac_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_state  <= ST_IDLE;
      cur_idx    <= '0;
      pos        <= '0;
      used_count <= '0;
      qi         <= '0;
      reply_mode <= 1'b0;
      drain_act  <= ACT_DROP;
      in_use     <= '0;
      resolved   <= '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        order[i] <= '0;
      end
    end else begin
      state      <= state_next;
      ret_state  <= ret_state_next;
      cur_idx    <= cur_idx_next;
      pos        <= pos_next;
      used_count <= used_count_next;
      qi         <= qi_next;
      reply_mode <= reply_mode_next;
      drain_act  <= drain_act_next;
      in_use     <= in_use_next;
      resolved   <= resolved_next;
      order      <= order_next;
    end
  end

  always_comb begin
    rec_t            wrec;
    logic            do_free;
    logic [UCW-1:0]  free_pos;
    logic [TIME_W-1:0] elapsed;

    wrec            = rec;
    do_free         = 1'b0;
    free_pos        = pos;
    elapsed         = now_q - mem_rdata.stamp;
    state_next      = state;
    ret_state_next  = ret_state;
    cur_idx_next    = cur_idx;
    pos_next        = pos;
    used_count_next = used_count;
    qi_next         = qi;
    reply_mode_next = reply_mode;
    drain_act_next  = drain_act;
    drain_mac_next  = drain_mac;
    rec_next        = rec;
    in_use_next     = in_use;
    resolved_next   = resolved;
    order_next      = order;
    mem_we          = 1'b0;
    mem_waddr       = cur_idx;
    mem_wdata       = rec;
    ctl             = '0;
    emit_data       = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_idx_next = '0;
          pos_next     = '0;
          priority if (opcode == OP_SEND) begin
            reply_mode_next = 1'b0;
            state_next      = ST_LK_WAIT;
          end else if (opcode == OP_FRAME && reply_ok) begin
            reply_mode_next = 1'b1;
            state_next      = ST_LK_WAIT;
          end else if (opcode == OP_FRAME && request_ok) begin
            state_next = ST_REQ_ANSWER;
          end else if (opcode == OP_TICK) begin
            state_next = ST_TICK_NEXT;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end

      ST_LK_WAIT: state_next = ST_LK_CHK;

      ST_LK_CHK: begin
        rec_next = mem_rdata;
        priority if (in_use[cur_idx] && mem_rdata.ip == key) begin
          if (reply_mode) begin
            state_next = resolved[cur_idx] ? ST_FINISH : ST_REPLY_FILL;
          end else begin
            state_next = resolved[cur_idx] ? ST_SEND_TX : ST_SEND_Q;
          end
        end else if (cur_idx == IW'(ENTRY_COUNT - 1)) begin
          priority if (reply_mode) begin
            state_next = ST_FINISH;
          end else if (used_count == UCW'(ENTRY_COUNT)) begin
            cur_idx_next = order[0];
            state_next   = ST_EV_WAIT;
          end else begin
            state_next = ST_ALLOC_SET;
          end
        end else begin
          cur_idx_next = cur_idx + 1'b1;
          state_next   = ST_LK_WAIT;
        end
      end

      ST_SEND_TX: begin
        if (room) begin
          ctl.emit         = 1'b1;
          emit_data.action = ACT_TX;
          emit_data.handle = handle_q;
          emit_data.mac    = rec.mac;
          state_next       = ST_FINISH;
        end
      end

      ST_SEND_Q: begin
        if (rec.count >= CW'(QUEUE_DEPTH)) begin
          if (room) begin
            ctl.emit         = 1'b1;
            emit_data.action = ACT_DROP;
            emit_data.handle = rec.handles[0];
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              wrec.handles[i] = rec.handles[i + 1];
            end
            wrec.handles[QUEUE_DEPTH-1] = handle_q;
            wrec.count = CW'(QUEUE_DEPTH);
            mem_we     = 1'b1;
            mem_wdata  = wrec;
            state_next = ST_FINISH;
          end
        end else begin
          wrec.handles[rec.count[QIW-1:0]] = handle_q;
          wrec.count = rec.count + 1'b1;
          mem_we     = 1'b1;
          mem_wdata  = wrec;
          state_next = ST_FINISH;
        end
      end

      ST_EV_WAIT: state_next = ST_EV_CHK;

      ST_EV_CHK: begin
        rec_next       = mem_rdata;
        do_free        = 1'b1;
        free_pos       = '0;
        qi_next        = '0;
        drain_act_next = ACT_DROP;
        drain_mac_next = '0;
        ret_state_next = ST_ALLOC_SET;
        state_next     = ST_DRAIN;
      end

      ST_ALLOC_SET: begin
        wrec.ip         = key;
        wrec.stamp      = now_q;
        wrec.retries    = '0;
        wrec.count      = CW'(1);
        wrec.handles[0] = handle_q;
        mem_we          = 1'b1;
        mem_waddr       = free_e;
        mem_wdata       = wrec;
        in_use_next[free_e]   = 1'b1;
        resolved_next[free_e] = 1'b0;
        order_next[used_count[IW-1:0]] = free_e;
        used_count_next = used_count + 1'b1;
        state_next      = ST_ALLOC_REQ;
      end

      ST_ALLOC_REQ: begin
        if (room) begin
          ctl.emit         = 1'b1;
          emit_data.action = ACT_REQ;
          emit_data.ip     = key;
          state_next       = ST_FINISH;
        end
      end

      ST_REPLY_FILL: begin
        wrec.mac   = smac_q;
        wrec.stamp = now_q;
        wrec.count = '0;
        mem_we     = 1'b1;
        mem_wdata  = wrec;
        resolved_next[cur_idx] = 1'b1;
        qi_next        = '0;
        drain_act_next = ACT_TX;
        drain_mac_next = smac_q;
        ret_state_next = ST_FINISH;
        state_next     = ST_DRAIN;
      end

      ST_REQ_ANSWER: begin
        if (room) begin
          ctl.emit         = 1'b1;
          emit_data.action = ACT_REPLY;
          emit_data.mac    = smac_q;
          emit_data.ip     = key;
          state_next       = ST_FINISH;
        end
      end

      ST_DRAIN: begin
        if (qi < rec.count) begin
          if (room) begin
            ctl.emit         = 1'b1;
            emit_data.action = drain_act;
            emit_data.handle = rec.handles[qi[QIW-1:0]];
            emit_data.mac    = drain_mac;
            qi_next          = qi + 1'b1;
          end
        end else begin
          state_next = ret_state;
        end
      end

      ST_TICK_NEXT: begin
        if (pos < used_count) begin
          cur_idx_next = order[pos[IW-1:0]];
          state_next   = ST_TK_WAIT;
        end else begin
          state_next = ST_FINISH;
        end
      end

      ST_TK_WAIT: state_next = ST_TK_CHK;

      ST_TK_CHK: begin
        rec_next   = mem_rdata;
        state_next = ST_TICK_NEXT;
        priority if (resolved[cur_idx]) begin
          if (elapsed > expire_ms) begin
            do_free = 1'b1;
          end else begin
            pos_next = pos + 1'b1;
          end
        end else if (elapsed > {16'd0, retry_ms}) begin
          if (mem_rdata.retries < max_retries) begin
            state_next = ST_TK_RETRY;
          end else begin
            do_free = 1'b1;
          end
        end else begin
          pos_next = pos + 1'b1;
        end
        if (do_free) begin
          qi_next        = '0;
          drain_act_next = ACT_DROP;
          drain_mac_next = '0;
          ret_state_next = ST_TICK_NEXT;
          state_next     = ST_DRAIN;
        end
      end

      ST_TK_RETRY: begin
        if (room) begin
          ctl.emit         = 1'b1;
          emit_data.action = ACT_REQ;
          emit_data.ip     = rec.ip;
          wrec.retries     = rec.retries + 1'b1;
          wrec.stamp       = now_q;
          mem_we           = 1'b1;
          mem_wdata        = wrec;
          pos_next         = pos + 1'b1;
          state_next       = ST_TICK_NEXT;
        end
      end

      ST_FINISH: begin
        if (room) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    if (do_free) begin
      in_use_next[order[free_pos[IW-1:0]]]   = 1'b0;
      resolved_next[order[free_pos[IW-1:0]]] = 1'b0;
      for (int i = 0; i < ENTRY_COUNT - 1; i++) begin
        if (UCW'(i) >= free_pos) begin
          order_next[i] = order[i + 1];
        end
      end
      used_count_next = used_count - 1'b1;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= UCW'(ENTRY_COUNT))
    else $error("allocation count past table size");
  a_used_match: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(used_count))
    else $error("in-use flags disagree with allocation count");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted beat not taken up");

endmodule

>>> tb/tb.sv
// Self-checking testbench of arp_cache_resolver_core: directed and random
// sends, ARP frames and ticks, checked beat by beat against an inline cache predictor.
// Depends on arpcr_pkg and the RTL of arp_cache_resolver_core.
`timescale 1ns / 1ps

module tb;
  import arpcr_pkg::*;

  localparam int NENT = 8;
  localparam int QDEP = 2;
  localparam int NPOOL = 12;

  typedef struct {
    logic [1:0]          op;
    logic [TIME_W-1:0]   now;
    logic [HANDLE_W-1:0] h;
    logic [IP_W-1:0]     dip;
    logic [10:0]         len;
    logic [15:0]         hw;
    logic [15:0]         pt;
    logic [15:0]         al;
    logic [15:0]         aop;
    logic [MAC_W-1:0]    smac;
    logic [IP_W-1:0]     sip;
    logic [IP_W-1:0]     tip;
  } arp_item_t;

  typedef struct {
    result_t r;
    logic    lst;
  } arp_beat_t;

  logic clk = 0;
  logic rst;
  logic in_valid, in_ready;
  logic [1:0] opcode;
  logic [TIME_W-1:0] now_ms;
  logic [HANDLE_W-1:0] packet_handle;
  logic [IP_W-1:0] dest_ip;
  logic [10:0] frame_length;
  logic [15:0] hw_type, proto_type, addr_lengths, arp_op;
  logic [MAC_W-1:0] sender_mac;
  logic [IP_W-1:0] sender_ip, tgt_ip;
  logic out_valid, out_ready;
  logic [1:0] action;
  logic [HANDLE_W-1:0] out_handle;
  logic [MAC_W-1:0] out_mac;
  logic [IP_W-1:0] out_ip;
  logic last;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  arp_cache_resolver_core dut (.*);

  // predictor state
  logic [IP_W-1:0]     own_ip_m;
  logic [15:0]         retry_iv_m;
  logic [TIME_W-1:0]   expire_iv_m;
  logic [RETRY_W-1:0]  max_retry_m;
  logic [IP_W-1:0]     ent_ip [NENT];
  logic [MAC_W-1:0]    ent_mac [NENT];
  bit                  ent_used [NENT];
  bit                  ent_res [NENT];
  logic [TIME_W-1:0]   ent_stamp [NENT];
  logic [RETRY_W-1:0]  ent_tries [NENT];
  logic [HANDLE_W-1:0] pend [NENT][QDEP];
  int                  pend_cnt [NENT];
  int                  order [NENT];
  int                  live_cnt;

  arp_beat_t pending_beats[$];
  arp_beat_t item_beats[$];
  int errors = 0;
  bit quiet = 0;
  logic [TIME_W-1:0] now_t = 32'hFFFF_F000;
  logic [IP_W-1:0] ip_pool [NPOOL];
  logic [IP_W-1:0] own_addr;

  initial forever #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void emit_beat(logic [1:0] a, logic [HANDLE_W-1:0] h,
                                    logic [MAC_W-1:0] m, logic [IP_W-1:0] ip);
    arp_beat_t b;
    if (item_beats.size() >= NENT * QDEP) return;
    b.r.action = a;
    b.r.handle = h;
    b.r.mac = m;
    b.r.ip = ip;
    b.lst = 1'b0;
    item_beats.push_back(b);
  endfunction

  function automatic int find_pos(logic [IP_W-1:0] ip);
    for (int p = 0; p < live_cnt; p++)
      if (ent_ip[order[p]] == ip) return p;
    return -1;
  endfunction

  function automatic void release_pos(int pos);
    int e;
    e = order[pos];
    for (int i = 0; i < pend_cnt[e]; i++) emit_beat(ACT_DROP, pend[e][i], '0, '0);
    pend_cnt[e] = 0;
    ent_used[e] = 0;
    ent_res[e] = 0;
    for (int i = pos; i + 1 < live_cnt; i++) order[i] = order[i + 1];
    live_cnt--;
  endfunction

  function automatic void queue_handle(int e, logic [HANDLE_W-1:0] h);
    if (pend_cnt[e] >= QDEP) begin
      emit_beat(ACT_DROP, pend[e][0], '0, '0);
      for (int i = 0; i + 1 < QDEP; i++) pend[e][i] = pend[e][i + 1];
      pend_cnt[e] = QDEP - 1;
    end
    pend[e][pend_cnt[e]] = h;
    pend_cnt[e]++;
  endfunction

  function automatic int alloc_entry();
    int e;
    if (live_cnt >= NENT) release_pos(0);
    for (e = 0; e + 1 < NENT; e++)
      if (!ent_used[e]) break;
    ent_used[e] = 1;
    ent_res[e] = 0;
    ent_tries[e] = '0;
    pend_cnt[e] = 0;
    order[live_cnt] = e;
    live_cnt++;
    return e;
  endfunction

  function automatic void predict_item(arp_item_t it);
    int p, e;
    logic [TIME_W-1:0] el;
    item_beats.delete();
    if (it.op == OP_SEND) begin
      p = find_pos(it.dip);
      if (p >= 0) begin
        e = order[p];
        if (ent_res[e]) emit_beat(ACT_TX, it.h, ent_mac[e], '0);
        else queue_handle(e, it.h);
      end else begin
        e = alloc_entry();
        ent_ip[e] = it.dip;
        ent_stamp[e] = it.now;
        queue_handle(e, it.h);
        emit_beat(ACT_REQ, '0, '0, it.dip);
      end
    end else if (it.op == OP_FRAME) begin
      if (it.len >= MIN_FRAME_LEN && it.hw == HW_ETHER && it.pt == PROTO_IPV4 &&
          it.al == ADDR_LENS) begin
        if (it.aop == ARP_REPLY) begin
          if (it.sip != it.tip && it.tip == own_ip_m) begin
            p = find_pos(it.sip);
            if (p >= 0 && !ent_res[order[p]]) begin
              e = order[p];
              ent_mac[e] = it.smac;
              ent_res[e] = 1;
              ent_stamp[e] = it.now;
              for (int i = 0; i < pend_cnt[e]; i++) emit_beat(ACT_TX, pend[e][i], it.smac, '0);
              pend_cnt[e] = 0;
            end
          end
        end else if (it.aop == ARP_REQUEST) begin
          if (it.sip != 0 && it.sip != it.tip && it.tip == own_ip_m)
            emit_beat(ACT_REPLY, '0, it.smac, it.sip);
        end
      end
    end else if (it.op == OP_TICK) begin
      p = 0;
      while (p < live_cnt) begin
        e = order[p];
        el = it.now - ent_stamp[e];
        if (ent_res[e]) begin
          if (el > expire_iv_m) begin
            release_pos(p);
            continue;
          end
        end else if (el > {16'd0, retry_iv_m}) begin
          if (ent_tries[e] < max_retry_m) begin
            emit_beat(ACT_REQ, '0, '0, ent_ip[e]);
            ent_tries[e] = ent_tries[e] + 1'b1;
            ent_stamp[e] = it.now;
          end else begin
            release_pos(p);
            continue;
          end
        end
        p++;
      end
    end
    if (item_beats.size() > 0) item_beats[item_beats.size() - 1].lst = 1'b1;
    foreach (item_beats[i]) pending_beats.push_back(item_beats[i]);
  endfunction

  task automatic send_item(arp_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= it.op;
    now_ms <= it.now;
    packet_handle <= it.h;
    dest_ip <= it.dip;
    frame_length <= it.len;
    hw_type <= it.hw;
    proto_type <= it.pt;
    addr_lengths <= it.al;
    arp_op <= it.aop;
    sender_mac <= it.smac;
    sender_ip <= it.sip;
    tgt_ip <= it.tip;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending_beats.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_idle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_OWN_IP:    own_ip_m = val;
      REG_RETRY:     retry_iv_m = val[15:0];
      REG_EXPIRE:    expire_iv_m = val;
      REG_MAX_RETRY: max_retry_m = val[RETRY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] own, logic [15:0] rtry, logic [31:0] expi,
                            logic [3:0] mx);
    own_addr = own;
    write_reg(REG_OWN_IP, own);
    write_reg(REG_RETRY, {16'd0, rtry});
    write_reg(REG_EXPIRE, expi);
    write_reg(REG_MAX_RETRY, {28'd0, mx});
  endtask

  function automatic arp_item_t noise_item();
    arp_item_t it;
    it.op = 2'($urandom_range(0, 3));
    it.now = now_t;
    it.h = HANDLE_W'($urandom);
    it.dip = $urandom;
    it.len = 11'($urandom);
    it.hw = 16'($urandom);
    it.pt = 16'($urandom);
    it.al = 16'($urandom);
    it.aop = 16'($urandom);
    it.smac = MAC_W'({$urandom, $urandom});
    it.sip = $urandom;
    it.tip = $urandom;
    return it;
  endfunction

  function automatic arp_item_t send_to(logic [IP_W-1:0] ip, logic [HANDLE_W-1:0] h);
    arp_item_t it;
    it = noise_item();
    it.op = OP_SEND;
    it.dip = ip;
    it.h = h;
    return it;
  endfunction

  function automatic arp_item_t frame(logic [15:0] aop, logic [IP_W-1:0] sip,
                                      logic [IP_W-1:0] tip);
    arp_item_t it;
    it = noise_item();
    it.op = OP_FRAME;
    it.len = 11'($urandom_range(MIN_FRAME_LEN, 2047));
    it.hw = HW_ETHER;
    it.pt = PROTO_IPV4;
    it.al = ADDR_LENS;
    it.aop = aop;
    it.sip = sip;
    it.tip = tip;
    return it;
  endfunction

  function automatic arp_item_t tick_at(int unsigned step);
    arp_item_t it;
    now_t += step;
    it = noise_item();
    it.op = OP_TICK;
    return it;
  endfunction

  task automatic test_send_paths();
    arp_item_t it;
    send_item(send_to(ip_pool[0], 8'h00));
    send_item(send_to(ip_pool[0], 8'hFF));
    send_item(send_to(ip_pool[0], 8'h5A));
    it = frame(ARP_REPLY, ip_pool[0], own_addr);
    it.len = MIN_FRAME_LEN;
    send_item(it);
    send_item(send_to(ip_pool[0], 8'hA5));
    send_item(frame(ARP_REPLY, ip_pool[0], own_addr));
    send_item(frame(ARP_REPLY, 32'hFFFF_FFFF, own_addr));
  endtask

  task automatic test_frame_filters();
    arp_item_t it;
    send_item(frame(ARP_REQUEST, ip_pool[1], own_addr));
    send_item(frame(ARP_REQUEST, 32'd0, own_addr));
    send_item(frame(ARP_REQUEST, own_addr, own_addr));
    send_item(frame(ARP_REQUEST, ip_pool[1], ~own_addr));
    send_item(frame(ARP_REPLY, own_addr, own_addr));
    it = frame(ARP_REQUEST, ip_pool[1], own_addr);
    it.len = MIN_FRAME_LEN - 1;
    send_item(it);
    it = frame(ARP_REQUEST, ip_pool[1], own_addr);
    it.hw = 16'h0006;
    send_item(it);
    it = frame(ARP_REQUEST, ip_pool[1], own_addr);
    it.pt = 16'h86DD;
    send_item(it);
    it = frame(ARP_REQUEST, ip_pool[1], own_addr);
    it.al = 16'h0610;
    send_item(it);
    send_item(frame(16'hFFFF, ip_pool[1], own_addr));
    it = noise_item();
    it.op = 2'd3;
    send_item(it);
  endtask

  task automatic test_table_full();
    for (int i = 1; i <= NENT + 1; i++) send_item(send_to(ip_pool[i], i[7:0]));
    send_item(send_to(ip_pool[3], 8'h33));
  endtask

  task automatic test_ticks();
    send_item(frame(ARP_REPLY, ip_pool[5], own_addr));
    send_item(tick_at(50));
    send_item(tick_at(150));
    send_item(tick_at(150));
    send_item(tick_at(150));
    send_item(tick_at(700));
  endtask

  task automatic test_random(int count);
    arp_item_t it;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 32) == 0) now_t += $urandom;
      else now_t += $urandom_range(0, 300);
      if (k < 45) begin
        if ($urandom_range(0, 19) == 0) it = send_to($urandom, HANDLE_W'($urandom));
        else it = send_to(ip_pool[$urandom_range(0, NPOOL - 1)], HANDLE_W'($urandom));
      end else if (k < 72) begin
        it = frame(ARP_REPLY, ip_pool[$urandom_range(0, NPOOL - 1)], own_addr);
      end else if (k < 82) begin
        it = frame(ARP_REQUEST, $urandom, own_addr);
      end else if (k < 94) begin
        it = tick_at(0);
      end else begin
        it = noise_item();
      end
      send_item(it);
    end
  endtask

  always @(posedge clk) begin
    arp_beat_t b;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat action %0d", action));
      end else begin
        b = pending_beats.pop_front();
        if (action !== b.r.action)
          report($sformatf("action %0d, want %0d", action, b.r.action));
        if (out_handle !== b.r.handle)
          report($sformatf("out_handle %h, want %h", out_handle, b.r.handle));
        if (out_mac !== b.r.mac)
          report($sformatf("out_mac %h, want %h", out_mac, b.r.mac));
        if (out_ip !== b.r.ip)
          report($sformatf("out_ip %h, want %h", out_ip, b.r.ip));
        if (last !== b.lst)
          report($sformatf("last %b, want %b", last, b.lst));
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (quiet) begin
        out_ready <= 1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    rst <= 1;
    in_valid <= 0;
    cfg_valid <= 0;
    cfg_index <= REG_OWN_IP;
    cfg_data <= '0;
    opcode <= OP_SEND;
    now_ms <= '0;
    packet_handle <= '0;
    dest_ip <= '0;
    frame_length <= '0;
    hw_type <= '0;
    proto_type <= '0;
    addr_lengths <= '0;
    arp_op <= '0;
    sender_mac <= '0;
    sender_ip <= '0;
    tgt_ip <= '0;
    own_ip_m = '0;
    retry_iv_m = RETRY_RESET;
    expire_iv_m = EXPIRE_RESET;
    max_retry_m = MAX_RETRY_RESET;
    live_cnt = 0;
    foreach (ent_used[i]) begin
      ent_used[i] = 0;
      ent_res[i] = 0;
      pend_cnt[i] = 0;
      order[i] = 0;
    end
    foreach (ip_pool[i]) ip_pool[i] = $urandom | 32'h1;
    own_addr = '0;
    repeat (8) @(posedge clk);
    rst <= 0;

    set_config($urandom | 32'h1, 16'd100, 32'd500, 4'd2);
    test_send_paths();
    test_frame_filters();
    test_table_full();
    test_ticks();

    set_config(ip_pool[NPOOL - 1] ^ 32'h8000_0001, 16'd400, 32'd3000, 4'd3);
    test_random(60);
    set_config(32'hFFFF_FFFF, 16'd0, 32'd0, 4'd0);
    test_random(40);
    set_config(32'd0, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
    test_random(40);
    set_config($urandom, 16'd250, 32'd2000, 4'd1);
    quiet = 1;
    test_random(50);

    wait_idle();
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
